@@ src/pte_pkg.sv @@
// Shared types, widths and register codes for the trajectory polynomial evaluator.
// No dependencies; every other file refers to this package by scoped names.
package pte_pkg;

  // Field and datapath widths
  localparam int TIME_W    = 16;  // unsigned Q4.12 sample time
  localparam int TIME_FRAC = 12;
  localparam int CFG_W     = 32;  // widest configuration register
  localparam int CFG_IDX_W = 3;
  localparam int COEF_W    = 38;  // Q16.16 coefficient times a weight up to 60
  localparam int ACC_W     = 53;  // Horner accumulator, magnitude below 2^52
  localparam int OUT_W     = 48;  // signed Q32.16 results
  localparam int PROD_W    = ACC_W + TIME_W + 1;

  // Lanes: position, velocity, acceleration, jerk
  localparam int NUM_LANES  = 4;
  localparam int NUM_ORDERS = 6;
  localparam int NUM_CELLS  = NUM_ORDERS - 1;

  localparam int LANE_POS  = 0;
  localparam int LANE_VEL  = 1;
  localparam int LANE_ACC  = 2;
  localparam int LANE_JERK = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ZERO   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ONE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_TWO    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_THREE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_FOUR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_FIVE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEGREE_MODE = 3'd6;

  // Degree mode codes
  localparam logic DEGREE_QUARTIC = 1'b0;
  localparam logic DEGREE_QUINTIC = 1'b1;

  // Rounding constant: one half in the dropped time fraction
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (TIME_FRAC - 1);

  localparam logic signed [ACC_W-1:0] OUT_MAX_EXT = ACC_W'((64'sd1 <<< (OUT_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] OUT_MIN_EXT = -(ACC_W'(64'sd1 <<< (OUT_W - 1)));

  typedef logic [NUM_LANES-1:0][COEF_W-1:0] coef_row_t;
  typedef coef_row_t [NUM_ORDERS-1:0]       coef_tab_t;
  typedef logic [NUM_LANES-1:0][ACC_W-1:0]  lanes_t;

  // Control that travels along the chain next to the accumulators
  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] t;
  } stage_t;

  // Derivative weight of coefficient order (order + lane) in lane 'lane':
  // (order + lane)! / order!, e.g. 20 for the t^5 term of acceleration.
  function automatic int deriv_weight(int lane, int order);
    int w;
    w = 1;
    for (int i = 1; i <= lane; i++) begin
      w = w * (order + i);
    end
    return w;
  endfunction

endpackage

@@ src/pte_coef_regs.sv @@
// Configuration registers: stores the derivative-scaled coefficient table per lane.
// Depends on pte_pkg.
module pte_coef_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pte_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [pte_pkg::CFG_W-1:0]     cfg_wdata_i,
  output pte_pkg::coef_tab_t            coef_o
);

  pte_pkg::coef_tab_t tab_q;
  pte_pkg::coef_tab_t scaled;
  logic               degree_q;
  logic signed [pte_pkg::COEF_W-1:0] wdata_ext;

  // Scale the written coefficient by each lane's derivative weight
  assign wdata_ext = pte_pkg::COEF_W'($signed(cfg_wdata_i));

  always_comb begin
    for (int o = 0; o < pte_pkg::NUM_ORDERS; o++) begin
      for (int l = 0; l < pte_pkg::NUM_LANES; l++) begin
        scaled[o][l] = pte_pkg::COEF_W'(wdata_ext *
          $signed(pte_pkg::COEF_W'(pte_pkg::deriv_weight(l, o))));
      end
    end
  end

  // Capture writes; entries beyond the lane's degree stay zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_q    <= '0;
      degree_q <= pte_pkg::DEGREE_QUINTIC;
    end else if (cfg_we_i) begin
      if (cfg_index_i == pte_pkg::REG_DEGREE_MODE) begin
        degree_q <= cfg_wdata_i[0];
      end
      for (int o = 0; o < pte_pkg::NUM_ORDERS; o++) begin
        for (int l = 0; l < pte_pkg::NUM_LANES; l++) begin
          if ((o + l < pte_pkg::NUM_ORDERS) &&
              (cfg_index_i == pte_pkg::REG_COEF_ZERO + pte_pkg::CFG_IDX_W'(o + l))) begin
            tab_q[o][l] <= scaled[o][l];
          end
        end
      end
    end
  end

  // Drop every term that comes from the fifth-order coefficient in quartic mode
  always_comb begin
    for (int o = 0; o < pte_pkg::NUM_ORDERS; o++) begin
      for (int l = 0; l < pte_pkg::NUM_LANES; l++) begin
        if ((degree_q == pte_pkg::DEGREE_QUARTIC) && (o + l == pte_pkg::NUM_ORDERS - 1)) begin
          coef_o[o][l] = '0;
        end else begin
          coef_o[o][l] = tab_q[o][l];
        end
      end
    end
  end

endmodule

@@ src/pte_cell.sv @@
// One Horner cell: acc = round(acc * t) + c for all four lanes, then register.
// Depends on pte_pkg.
module pte_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  pte_pkg::stage_t    stage_i,
  input  pte_pkg::lanes_t    acc_i,
  input  pte_pkg::coef_row_t coef_i,
  output pte_pkg::stage_t    stage_o,
  output pte_pkg::lanes_t    acc_o
);

  logic                                  valid_q;
  logic [pte_pkg::TIME_W-1:0]            t_q;
  pte_pkg::lanes_t                       acc_q;
  pte_pkg::lanes_t                       acc_d;
  logic signed [pte_pkg::PROD_W-1:0]     prod  [pte_pkg::NUM_LANES];
  logic signed [pte_pkg::PROD_W-1:0]     rsum  [pte_pkg::NUM_LANES];

  // Multiply by time, round to nearest (ties up), add this cell's coefficient
  always_comb begin
    for (int l = 0; l < pte_pkg::NUM_LANES; l++) begin
      prod[l]  = $signed(acc_i[l]) * $signed({1'b0, stage_i.t});
      rsum[l]  = prod[l] + pte_pkg::ROUND_HALF;
      acc_d[l] = rsum[l][pte_pkg::ACC_W+pte_pkg::TIME_FRAC-1:pte_pkg::TIME_FRAC]
               + pte_pkg::ACC_W'($signed(coef_i[l]));
    end
  end

  // Advance the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= stage_i.valid;
    end
  end

  // Advance the payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q   <= stage_i.t;
      acc_q <= acc_d;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.t     = t_q;
  assign acc_o         = acc_q;

endmodule

@@ src/pte_sat.sv @@
// Output register: clamps each lane to the signed 48-bit range and flags clipping.
// Depends on pte_pkg.
module pte_sat (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  pte_pkg::lanes_t           acc_i,
  output logic                      valid_o,
  output logic [pte_pkg::OUT_W-1:0] position_o,
  output logic [pte_pkg::OUT_W-1:0] velocity_o,
  output logic [pte_pkg::OUT_W-1:0] acceleration_o,
  output logic [pte_pkg::OUT_W-1:0] jerk_o,
  output logic                      saturated_o
);

  logic                                             valid_q;
  logic [pte_pkg::NUM_LANES-1:0][pte_pkg::OUT_W-1:0] res_q;
  logic [pte_pkg::NUM_LANES-1:0][pte_pkg::OUT_W-1:0] res_d;
  logic [pte_pkg::NUM_LANES-1:0]                     clip;
  logic                                             sat_q;

  // Clamp each lane
  always_comb begin
    for (int l = 0; l < pte_pkg::NUM_LANES; l++) begin
      if ($signed(acc_i[l]) > pte_pkg::OUT_MAX_EXT) begin
        res_d[l] = pte_pkg::OUT_MAX_EXT[pte_pkg::OUT_W-1:0];
        clip[l]  = 1'b1;
      end else if ($signed(acc_i[l]) < pte_pkg::OUT_MIN_EXT) begin
        res_d[l] = pte_pkg::OUT_MIN_EXT[pte_pkg::OUT_W-1:0];
        clip[l]  = 1'b1;
      end else begin
        res_d[l] = acc_i[l][pte_pkg::OUT_W-1:0];
        clip[l]  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Hold the result while the consumer stalls
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
      sat_q <= |clip;
    end
  end

  assign valid_o        = valid_q;
  assign position_o     = res_q[pte_pkg::LANE_POS];
  assign velocity_o     = res_q[pte_pkg::LANE_VEL];
  assign acceleration_o = res_q[pte_pkg::LANE_ACC];
  assign jerk_o         = res_q[pte_pkg::LANE_JERK];
  assign saturated_o    = sat_q;

endmodule

@@ src/polynomial_trajectory_evaluator_core.sv @@
// Trajectory polynomial evaluator: position and three derivatives per sample time.
// Pipeline: five Horner cells, the first of which captures at the accepting edge, then
// the clamping output register, which comes last.
// Throughput: one request per cycle; the chain moves as a whole and holds only while
// a finished result is stalled.
// Reset: pipeline empties, coefficients clear to zero, degree mode is quintic.
// Depends on pte_pkg, pte_coef_regs, pte_cell and pte_sat.
module polynomial_trajectory_evaluator_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [pte_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [pte_pkg::CFG_W-1:0]     cfg_wdata_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [pte_pkg::TIME_W-1:0]    sample_time_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pte_pkg::OUT_W-1:0]     position_o,
  output logic [pte_pkg::OUT_W-1:0]     velocity_o,
  output logic [pte_pkg::OUT_W-1:0]     acceleration_o,
  output logic [pte_pkg::OUT_W-1:0]     jerk_o,
  output logic                          saturated_o
);

  pte_pkg::coef_tab_t coef;
  pte_pkg::stage_t    stage [pte_pkg::NUM_CELLS+1];
  pte_pkg::lanes_t    acc   [pte_pkg::NUM_CELLS+1];
  logic               en;

  pte_coef_regs u_coef_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .coef_o      (coef)
  );

  // Advance the whole chain unless a finished result is held
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // Seed each lane with its highest-order coefficient
  assign stage[0].valid = in_valid_i;
  assign stage[0].t     = sample_time_i;
  always_comb begin
    for (int l = 0; l < pte_pkg::NUM_LANES; l++) begin
      acc[0][l] = pte_pkg::ACC_W'($signed(coef[pte_pkg::NUM_ORDERS-1][l]));
    end
  end

  // One cell per Horner step, descending coefficient order
  for (genvar k = 0; k < pte_pkg::NUM_CELLS; k++) begin : g_cell
    pte_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .stage_i (stage[k]),
      .acc_i   (acc[k]),
      .coef_i  (coef[pte_pkg::NUM_CELLS-1-k]),
      .stage_o (stage[k+1]),
      .acc_o   (acc[k+1])
    );
  end

  pte_sat u_sat (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (stage[pte_pkg::NUM_CELLS].valid),
    .acc_i          (acc[pte_pkg::NUM_CELLS]),
    .valid_o        (out_valid_o),
    .position_o     (position_o),
    .velocity_o     (velocity_o),
    .acceleration_o (acceleration_o),
    .jerk_o         (jerk_o),
    .saturated_o    (saturated_o)
  );

  // Input is held back only by a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // A result leaving the last cell shows up at the output next cycle
  a_last_cell_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage[pte_pkg::NUM_CELLS].valid && en) |=> out_valid_o)
    else $error("result lost between last cell and output register");

  // A clipped result carries at least one value at a range limit
  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |->
      (position_o == pte_pkg::OUT_MAX_EXT[pte_pkg::OUT_W-1:0] ||
       position_o == pte_pkg::OUT_MIN_EXT[pte_pkg::OUT_W-1:0] ||
       velocity_o == pte_pkg::OUT_MAX_EXT[pte_pkg::OUT_W-1:0] ||
       velocity_o == pte_pkg::OUT_MIN_EXT[pte_pkg::OUT_W-1:0] ||
       acceleration_o == pte_pkg::OUT_MAX_EXT[pte_pkg::OUT_W-1:0] ||
       acceleration_o == pte_pkg::OUT_MIN_EXT[pte_pkg::OUT_W-1:0] ||
       jerk_o == pte_pkg::OUT_MAX_EXT[pte_pkg::OUT_W-1:0] ||
       jerk_o == pte_pkg::OUT_MIN_EXT[pte_pkg::OUT_W-1:0]))
    else $error("saturation flag set with no clipped value");

endmodule
